// ===== hdl/segrb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Segment reorder buffer package
// Item types, codes, sequencer states and serial-number compares.
// ----------------------------------------------------------------------------
package segrb_pkg;

    localparam logic [1:0] OP_PUT  = 2'd0;
    localparam logic [1:0] OP_READ = 2'd1;
    localparam logic [1:0] OP_SACK = 2'd2;
    localparam logic [1:0] OP_RSVD = 2'd3;

    localparam logic [1:0] KIND_PUT  = 2'd0;
    localparam logic [1:0] KIND_RUN  = 2'd1;
    localparam logic [1:0] KIND_PAIR = 2'd2;
    localparam logic [1:0] KIND_NONE = 2'd3;

    localparam logic [2:0] ST_OK  = 3'd0;
    localparam logic [2:0] ST_DUP = 3'd1;
    localparam logic [2:0] ST_BAD = 3'd2;
    localparam logic [2:0] ST_OVF = 3'd3;
    localparam logic [2:0] ST_OLD = 3'd4;

    localparam logic [0:0]  REG_MAX_SEG   = 1'b0;
    localparam logic [15:0] MAX_SEG_RESET = 16'd4096;
    localparam logic [4:0]  MAX_RESULTS   = 5'd16;

    typedef struct packed {
        logic [1:0]  operation;
        logic [31:0] seq_start;
        logic [15:0] seg_length;
        logic [19:0] limit;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  result_kind;
        logic [2:0]  put_status;
        logic [3:0]  slot;
        logic [15:0] run_offset;
        logic [15:0] run_count;
        logic [31:0] pair_left;
        logic [31:0] pair_right;
        logic        last;
        logic [31:0] ack_seq;
        logic [19:0] inorder_bytes;
        logic        has_data;
        logic [4:0]  filled_slots;
    } t_out_item;

    typedef struct packed {
        logic [1:0]  kind;
        logic [2:0]  status;
        logic [3:0]  slot;
        logic [15:0] offset;
        logic [15:0] count;
        logic [31:0] left;
        logic [31:0] right;
    } t_entry;

    typedef enum logic [4:0] {
        S_IDLE,
        S_PUT0,
        S_PUT_FIRST,
        S_PUT_LAST,
        S_PUT_IEND,
        S_PUT_SCAN,
        S_INSERT,
        S_EXT0,
        S_EXT1,
        S_EXT_SCAN,
        S_READ,
        S_READ_END,
        S_ACK0,
        S_ACK1,
        S_ACK_SCAN,
        S_STAT0,
        S_STAT1,
        S_STAT2,
        S_OUT
    } t_state;

    function automatic logic w_gt(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] d;
        d = a - b;
        return (d != 32'd0) && !d[31];
    endfunction

    function automatic logic w_lt(input logic [31:0] a, input logic [31:0] b);
        return w_gt(b, a);
    endfunction

endpackage

// ===== hdl/segment_reorder_buffer_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Segment reorder buffer
// Descriptor engine that keeps received segments in sequence order, hands
// out payload slots, returns in-order read runs and lists out-of-order ranges.
// ----------------------------------------------------------------------------
// One item is taken at a time; ready stays low until every result item of
// the previous one has been loaded into the output register. A sequencer walks
// the ordered descriptor list through a single read port, one descriptor per
// cycle: a put walks the descriptors it needs for placement and then the
// in-order run it extends, a read walks each descriptor it reaches, and an ack
// query walks the descriptors after the in-order run. Every item then passes
// through the status states S_STAT0, S_STAT1 and S_STAT2 and loads its result
// items into the output register one at a time, holding while the output is
// not taken. Payload bytes live outside, indexed by slot.
module segment_reorder_buffer_top #(
    parameter int NODES = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  segrb_pkg::t_in_item  i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output segrb_pkg::t_out_item o_out_data,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    localparam int IW = (NODES > 1) ? $clog2(NODES) : 1;
    localparam int CW = $clog2(NODES + 1);
    localparam int RW = 16 + CW;

    segrb_pkg::t_state r_state, n_state;

    logic [15:0]          r_max;
    segrb_pkg::t_in_item  r_in;
    logic [31:0]          r_seq [NODES];
    logic [15:0]          r_len [NODES];
    logic [IW-1:0]        r_ol  [NODES];
    logic [CW-1:0]        r_used;
    logic [NODES-1:0]     r_free;
    logic [31:0]          r_rpos;
    logic [15:0]          r_hoff;
    logic [CW-1:0]        r_iend;
    logic [RW-1:0]        r_ready;
    logic [CW-1:0]        r_pos;
    logic [31:0]          r_first;
    logic [31:0]          r_ack;
    logic [31:0]          r_s0;
    logic [19:0]          r_copied;
    logic [4:0]           r_n;
    logic [CW-1:0]        r_ins_pos;
    logic [IW-1:0]        r_ins_slot;
    segrb_pkg::t_entry    r_res [16];
    logic [4:0]           r_oidx;
    segrb_pkg::t_out_item r_out;
    logic                 r_ovalid;
    logic [31:0]          r_st_ack;
    logic                 r_st_hd;
    logic [19:0]          r_st_avail;
    logic [4:0]           r_st_fill;

    logic [IW-1:0] rd_slot;
    logic [31:0]   rd_seq, rd_end;
    logic [15:0]   rd_len;
    logic          fs_found;
    logic [IW-1:0] fs_idx;
    logic          iend_ok, pos_end;
    logic [31:0]   s_seq, s_end;
    logic [15:0]   s_len;

    logic          in_acc, out_load, res_we;
    segrb_pkg::t_entry res_entry;

    logic          p0_fin, p0_empty;
    logic [2:0]    p0_status;
    logic          pl_ovf, pl_app, pl_bad, pl_fin;
    logic          pi_dup;
    logic          ps_gt, ps_lt, ps_skip, ps_ins, ps_fin;
    logic [2:0]    ps_status;
    logic          rl_go, rl_free, rl_stop;
    logic [15:0]   rl_left, rl_take, rl_hoff;
    logic [19:0]   rl_rem, rl_copied;
    logic          ak_room;

    assign rd_slot = r_ol[r_pos[IW-1:0]];
    assign rd_seq  = r_seq[rd_slot];
    assign rd_len  = r_len[rd_slot];
    assign rd_end  = rd_seq + 32'(rd_len);
    assign iend_ok = r_iend < CW'(NODES);
    assign pos_end = r_pos >= r_used;
    assign s_seq   = r_in.seq_start;
    assign s_len   = r_in.seg_length;
    assign s_end   = s_seq + 32'(s_len);

    always_comb begin
        fs_found = 1'b0;
        fs_idx   = '0;
        for (int i = NODES - 1; i >= 0; i--) begin
            if (r_free[i]) begin
                fs_found = 1'b1;
                fs_idx   = IW'(i);
            end
        end
    end

    // put classification
    always_comb begin
        p0_empty  = r_used == '0;
        p0_fin    = 1'b1;
        p0_status = segrb_pkg::ST_OVF;
        if (s_len > r_max) begin
            p0_status = segrb_pkg::ST_BAD;
        end else if (!segrb_pkg::w_gt(s_end, r_rpos)) begin
            p0_status = segrb_pkg::ST_OLD;
        end else if (r_used >= CW'(NODES) || !fs_found) begin
            p0_status = segrb_pkg::ST_OVF;
        end else begin
            p0_fin = 1'b0;
        end
    end

    assign pl_ovf = segrb_pkg::w_gt(r_first, r_rpos) &&
                    ((CW + 1)'(r_used) + (CW + 1)'(1) >= (CW + 1)'(NODES)) &&
                    (s_seq != r_rpos);
    assign pl_app = !segrb_pkg::w_lt(s_seq, rd_end);
    assign pl_bad = segrb_pkg::w_lt(s_seq, r_rpos) && segrb_pkg::w_gt(s_end, r_rpos) &&
                    segrb_pkg::w_lt(s_end, r_first);
    assign pl_fin = pl_ovf || (!pl_app && pl_bad);
    assign pi_dup = !segrb_pkg::w_gt(s_seq, rd_seq);

    assign ps_gt     = segrb_pkg::w_gt(s_seq, rd_seq);
    assign ps_lt     = segrb_pkg::w_lt(s_seq, rd_seq);
    assign ps_skip   = !pos_end && ps_gt && !segrb_pkg::w_lt(s_seq, rd_end);
    assign ps_ins    = !pos_end && !ps_gt && ps_lt && !segrb_pkg::w_gt(s_end, rd_seq);
    assign ps_fin    = !ps_skip && !ps_ins;
    assign ps_status = (!pos_end && !ps_gt && !ps_lt && s_end == rd_end) ?
                       segrb_pkg::ST_DUP : segrb_pkg::ST_BAD;

    // read walk
    assign rl_go     = (r_used != '0) && (r_n < segrb_pkg::MAX_RESULTS) &&
                       !segrb_pkg::w_gt(rd_seq, r_rpos + 32'(r_copied));
    assign rl_left   = (r_hoff <= rd_len) ? rd_len - r_hoff : 16'd0;
    assign rl_rem    = r_in.limit - r_copied;
    assign rl_take   = (rl_rem < 20'(rl_left)) ? rl_rem[15:0] : rl_left;
    assign rl_hoff   = r_hoff + rl_take;
    assign rl_copied = r_copied + 20'(rl_take);
    assign rl_free   = rl_hoff == rd_len;
    assign rl_stop   = rl_copied == r_in.limit;

    assign ak_room = (21'(r_n) + 21'd1 <= 21'(r_in.limit)) &&
                     (r_n < segrb_pkg::MAX_RESULTS);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            segrb_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    unique case (i_in_data.operation)
                        segrb_pkg::OP_PUT:  n_state = segrb_pkg::S_PUT0;
                        segrb_pkg::OP_READ: n_state = segrb_pkg::S_READ;
                        segrb_pkg::OP_SACK: n_state = segrb_pkg::S_ACK0;
                        default:            n_state = segrb_pkg::S_STAT0;
                    endcase
                end
            end
            segrb_pkg::S_PUT0: begin
                if (p0_fin) n_state = segrb_pkg::S_STAT0;
                else if (p0_empty) n_state = segrb_pkg::S_INSERT;
                else n_state = segrb_pkg::S_PUT_FIRST;
            end
            segrb_pkg::S_PUT_FIRST: n_state = segrb_pkg::S_PUT_LAST;
            segrb_pkg::S_PUT_LAST: begin
                if (pl_fin) n_state = segrb_pkg::S_STAT0;
                else if (pl_app) n_state = segrb_pkg::S_INSERT;
                else if (iend_ok) n_state = segrb_pkg::S_PUT_IEND;
                else n_state = segrb_pkg::S_PUT_SCAN;
            end
            segrb_pkg::S_PUT_IEND: begin
                n_state = pi_dup ? segrb_pkg::S_STAT0 : segrb_pkg::S_PUT_SCAN;
            end
            segrb_pkg::S_PUT_SCAN: begin
                if (ps_ins) n_state = segrb_pkg::S_INSERT;
                else if (ps_fin) n_state = segrb_pkg::S_STAT0;
            end
            segrb_pkg::S_INSERT: n_state = segrb_pkg::S_EXT0;
            segrb_pkg::S_EXT0: begin
                if (iend_ok) n_state = segrb_pkg::S_EXT1;
                else if (rd_seq != r_rpos) n_state = segrb_pkg::S_STAT0;
                else n_state = segrb_pkg::S_EXT_SCAN;
            end
            segrb_pkg::S_EXT1: n_state = segrb_pkg::S_EXT_SCAN;
            segrb_pkg::S_EXT_SCAN: begin
                if (pos_end || rd_seq != r_ack) n_state = segrb_pkg::S_STAT0;
            end
            segrb_pkg::S_READ: begin
                if (!rl_go || rl_stop) n_state = segrb_pkg::S_READ_END;
            end
            segrb_pkg::S_READ_END: n_state = segrb_pkg::S_STAT0;
            segrb_pkg::S_ACK0: begin
                if (r_used == '0) n_state = segrb_pkg::S_STAT0;
                else if (!iend_ok) n_state = segrb_pkg::S_ACK1;
                else if ((CW + 1)'(r_iend) + (CW + 1)'(1) >= (CW + 1)'(r_used))
                    n_state = segrb_pkg::S_STAT0;
                else n_state = segrb_pkg::S_ACK1;
            end
            segrb_pkg::S_ACK1: n_state = segrb_pkg::S_ACK_SCAN;
            segrb_pkg::S_ACK_SCAN: begin
                if (pos_end) n_state = segrb_pkg::S_STAT0;
                else if (rd_seq != r_ack && !ak_room) n_state = segrb_pkg::S_STAT0;
            end
            segrb_pkg::S_STAT0: n_state = segrb_pkg::S_STAT1;
            segrb_pkg::S_STAT1: n_state = segrb_pkg::S_STAT2;
            segrb_pkg::S_STAT2: n_state = segrb_pkg::S_OUT;
            segrb_pkg::S_OUT: begin
                if (out_load && (r_oidx + 5'd1 == r_n)) n_state = segrb_pkg::S_IDLE;
            end
            default: n_state = segrb_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready = r_state == segrb_pkg::S_IDLE;
        in_acc     = o_in_ready && i_in_valid;
        out_load   = (r_state == segrb_pkg::S_OUT) && (!r_ovalid || i_out_ready);
        res_we     = 1'b0;
        res_entry  = '0;
        unique case (r_state)
            segrb_pkg::S_PUT0: begin
                res_we = p0_fin;
                res_entry.status = p0_status;
            end
            segrb_pkg::S_PUT_LAST: begin
                res_we = pl_fin;
                res_entry.status = pl_ovf ? segrb_pkg::ST_OVF : segrb_pkg::ST_BAD;
            end
            segrb_pkg::S_PUT_IEND: begin
                res_we = pi_dup;
                res_entry.status = segrb_pkg::ST_DUP;
            end
            segrb_pkg::S_PUT_SCAN: begin
                res_we = ps_fin;
                res_entry.status = ps_status;
            end
            segrb_pkg::S_INSERT: begin
                res_we = 1'b1;
                res_entry.status = segrb_pkg::ST_OK;
                res_entry.slot   = 4'(r_ins_slot);
            end
            segrb_pkg::S_READ: begin
                res_we = rl_go && (rl_take != 16'd0);
                res_entry.kind   = segrb_pkg::KIND_RUN;
                res_entry.slot   = 4'(rd_slot);
                res_entry.offset = r_hoff;
                res_entry.count  = rl_take;
            end
            segrb_pkg::S_ACK_SCAN: begin
                res_we = (pos_end || rd_seq != r_ack) && ak_room;
                res_entry.kind  = segrb_pkg::KIND_PAIR;
                res_entry.left  = r_s0;
                res_entry.right = r_ack - 32'd1;
            end
            segrb_pkg::S_STAT0: begin
                res_we = r_n == 5'd0;
                res_entry.kind = segrb_pkg::KIND_NONE;
            end
            default: res_we = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= segrb_pkg::S_IDLE;
            r_max    <= segrb_pkg::MAX_SEG_RESET;
            r_used   <= '0;
            r_free   <= '1;
            r_rpos   <= '0;
            r_hoff   <= '0;
            r_iend   <= CW'(NODES);
            r_ready  <= '0;
            r_ovalid <= 1'b0;
            r_n      <= '0;
            r_oidx   <= '0;
        end else begin
            r_state <= n_state;

            if (psel && penable && pwrite && paddr[2] == segrb_pkg::REG_MAX_SEG) begin
                r_max <= pwdata[15:0];
            end

            if (in_acc) begin
                r_in     <= i_in_data;
                r_n      <= '0;
                r_pos    <= '0;
                r_copied <= '0;
            end

            if (res_we) begin
                r_res[r_n[3:0]] <= res_entry;
                r_n             <= r_n + 5'd1;
            end

            unique case (r_state)
                segrb_pkg::S_PUT0: begin
                    r_ins_slot <= fs_idx;
                    r_ins_pos  <= '0;
                    r_pos      <= '0;
                end
                segrb_pkg::S_PUT_FIRST: begin
                    r_first <= rd_seq;
                    r_pos   <= r_used - CW'(1);
                end
                segrb_pkg::S_PUT_LAST: begin
                    r_ins_pos <= r_used;
                    r_pos     <= iend_ok ? r_iend : '0;
                end
                segrb_pkg::S_PUT_SCAN: begin
                    r_ins_pos <= r_pos;
                    if (ps_skip) r_pos <= r_pos + CW'(1);
                end
                segrb_pkg::S_INSERT: begin
                    r_seq[r_ins_slot] <= s_seq;
                    r_len[r_ins_slot] <= s_len;
                    for (int i = 1; i < NODES; i++) begin
                        if (CW'(i) > r_ins_pos && CW'(i) <= r_used) r_ol[i] <= r_ol[i-1];
                    end
                    r_ol[r_ins_pos[IW-1:0]] <= r_ins_slot;
                    r_free[r_ins_slot] <= 1'b0;
                    r_used <= r_used + CW'(1);
                    if (iend_ok && r_ins_pos <= r_iend) r_iend <= r_iend + CW'(1);
                    r_pos <= '0;
                end
                segrb_pkg::S_EXT0: begin
                    if (iend_ok) begin
                        r_pos <= r_iend;
                    end else if (rd_seq == r_rpos) begin
                        r_iend  <= '0;
                        r_ready <= RW'(rd_len);
                        r_ack   <= rd_end;
                        r_pos   <= CW'(1);
                    end
                end
                segrb_pkg::S_EXT1: begin
                    r_ack <= rd_end;
                    r_pos <= r_pos + CW'(1);
                end
                segrb_pkg::S_EXT_SCAN: begin
                    if (!pos_end && rd_seq == r_ack) begin
                        r_ack   <= rd_end;
                        r_iend  <= r_pos;
                        r_ready <= r_ready + RW'(rd_len);
                        r_pos   <= r_pos + CW'(1);
                    end
                end
                segrb_pkg::S_READ: begin
                    if (rl_go) begin
                        r_copied <= rl_copied;
                        if (rl_free) begin
                            r_hoff <= '0;
                            r_free[rd_slot] <= 1'b1;
                            for (int i = 0; i < NODES - 1; i++) r_ol[i] <= r_ol[i+1];
                            r_used <= r_used - CW'(1);
                            if (iend_ok) begin
                                r_iend <= (r_iend == '0) ? CW'(NODES) : r_iend - CW'(1);
                            end
                        end else begin
                            r_hoff <= rl_hoff;
                        end
                    end
                end
                segrb_pkg::S_READ_END: begin
                    r_rpos <= r_rpos + 32'(r_copied);
                    if (32'(r_ready) >= 32'(r_copied)) r_ready <= r_ready - RW'(r_copied);
                    else r_ready <= '0;
                end
                segrb_pkg::S_ACK0: begin
                    r_pos <= iend_ok ? r_iend + CW'(1) : '0;
                end
                segrb_pkg::S_ACK1: begin
                    r_s0  <= rd_seq;
                    r_ack <= rd_end;
                    r_pos <= r_pos + CW'(1);
                end
                segrb_pkg::S_ACK_SCAN: begin
                    if (!pos_end) begin
                        if (rd_seq != r_ack) r_s0 <= rd_seq;
                        r_ack <= rd_end;
                        r_pos <= r_pos + CW'(1);
                    end
                end
                segrb_pkg::S_STAT0: begin
                    r_pos <= r_iend;
                end
                segrb_pkg::S_STAT1: begin
                    r_st_ack <= (iend_ok && r_iend < r_used) ? rd_end : r_rpos;
                    r_pos    <= '0;
                end
                segrb_pkg::S_STAT2: begin
                    if (r_hoff != 16'd0) r_st_hd <= 1'b1;
                    else if (r_used == '0) r_st_hd <= 1'b0;
                    else r_st_hd <= r_rpos == rd_seq;
                    r_st_avail <= (32'(r_ready) > 32'hFFFFF) ? 20'hFFFFF : 20'(r_ready);
                    r_st_fill  <= 5'(r_used);
                    r_oidx     <= '0;
                end
                default: ;
            endcase

            if (out_load) begin
                r_out.result_kind   <= r_res[r_oidx[3:0]].kind;
                r_out.put_status    <= r_res[r_oidx[3:0]].status;
                r_out.slot          <= r_res[r_oidx[3:0]].slot;
                r_out.run_offset    <= r_res[r_oidx[3:0]].offset;
                r_out.run_count     <= r_res[r_oidx[3:0]].count;
                r_out.pair_left     <= r_res[r_oidx[3:0]].left;
                r_out.pair_right    <= r_res[r_oidx[3:0]].right;
                r_out.last          <= r_oidx + 5'd1 == r_n;
                r_out.ack_seq       <= r_st_ack;
                r_out.inorder_bytes <= r_st_avail;
                r_out.has_data      <= r_st_hd;
                r_out.filled_slots  <= r_st_fill;
                r_ovalid            <= 1'b1;
                r_oidx              <= r_oidx + 5'd1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_out;
    assign pready      = 1'b1;
    assign prdata      = (paddr[2] == segrb_pkg::REG_MAX_SEG) ? {16'd0, r_max} : 32'd0;

endmodule
